// ===== rtl/core/mpuacl_pkg.sv =====
// Package for the region table: sizes, scan token and write command types,
// FSM states and the bit-length helper. Depends on nothing.
`default_nettype none

package mpuacl_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int DYN_REGIONS   = 3;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OUT_IDX_W     = 4;
    localparam int SLOT_W        = 3;

    localparam logic [31:0] MIN_SIZE = 32'd32;
    localparam logic [5:0]  MIN_BITS = 6'd8;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ARG = 2'd1,
        ST_FULL    = 2'd2,
        ST_DENIED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_PREP = 2'd1,
        FSM_SCAN = 2'd2,
        FSM_DONE = 2'd3
    } fsm_t;

    typedef enum logic {
        FUNC_SET   = 1'b0,
        FUNC_FAULT = 1'b1
    } func_t;

    // Token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic             vld;
        func_t            func;
        logic [31:0]      base;
        logic [31:0]      addr;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [31:0]      hit_base;
        logic [31:0]      hit_attr;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } scan_tok_t;

    // Write command broadcast to all cells.
    typedef struct packed {
        logic             en;
        logic             clear;
        logic [IDX_W-1:0] idx;
        logic [31:0]      base;
        logic [31:0]      attr;
        logic [7:0]       prio;
    } cell_wr_t;

    function automatic logic [5:0] bit_len(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

endpackage : mpuacl_pkg

`default_nettype wire

// ===== rtl/core/mpu_acl_region_table.sv =====
// Top level of the region table: control FSM, attribute prep, cell chain and
// result register. Depends on mpuacl_pkg and mpuacl_cell.
`default_nettype none

// Channel | Dir | tdata fields (low bit up)                               | tuser
// s_      | in  | region_base 32, region_size 32, region_priority 8,      | func
//         |     | attr_flags 32, fault_address 32 (136 bits)              |
// m_      | out | status 2, entry_index 4, dyn_slot 3, base_word 32,      | -
//         |     | attr_word 32 (73 bits, padded to 80)                    |
//
// Steps: each beat passes accept, attribute prep, the scan as the token walks
// the cell chain, and a decide/write step.
// Reset: aresetn low clears all entry valid bits, the dynamic slot counter,
// the FSM and the output valid. No clearing pass.
// Stalls: a finished result waits in the output register; the next beat is
// accepted meanwhile and holds in the decide cycle until the register frees.
module mpu_acl_region_table (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] region_base, [63:32] region_size, [71:64] region_priority,
    // [103:72] attr_flags, [135:104] fault_address
    input  wire logic [135:0] s_tdata,
    // [0] func
    input  wire logic         s_tuser,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [1:0] status, [5:2] entry_index, [8:6] dyn_slot, [40:9] base_word,
    // [72:41] attr_word, [79:73] zero
    output logic [79:0]       m_tdata
);
    import mpuacl_pkg::*;

    fsm_t state_reg, state_next;

    // captured beat
    func_t       func_reg;
    logic [31:0] base_in_reg;
    logic [31:0] size_in_reg;
    logic [7:0]  prio_in_reg;
    logic [31:0] flags_in_reg;
    logic [31:0] addr_in_reg;

    // prep results
    logic        align_fail_reg;
    logic [31:0] attr_new_reg;

    scan_tok_t   res_tok_reg;
    logic [SLOT_W-1:0] dyn_cnt_reg, dyn_cnt_next;

    logic        m_valid_reg;
    logic [79:0] m_data_reg;

    scan_tok_t   tok [TABLE_ENTRIES+1];
    scan_tok_t   head_tok;
    cell_wr_t    wr;

    logic        in_beat;
    logic        out_free;
    logic        load_out;
    logic [72:0] res_pack;

    // prep datapath
    logic [31:0] sz_clamped;
    logic [5:0]  bl;
    logic [4:0]  lg;
    logic [4:0]  lg_m1;
    logic [31:0] align_mask;
    logic [3:0]  cnt_inc;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == FSM_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (state_reg == FSM_DONE) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (in_beat) begin
                    state_next = FSM_PREP;
                end
            end
            FSM_PREP: begin
                state_next = FSM_SCAN;
            end
            FSM_SCAN: begin
                if (tok[TABLE_ENTRIES].vld) begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            func_reg     <= func_t'(s_tuser);
            base_in_reg  <= s_tdata[31:0];
            size_in_reg  <= s_tdata[63:32];
            prio_in_reg  <= s_tdata[71:64];
            flags_in_reg <= s_tdata[103:72];
            addr_in_reg  <= s_tdata[135:104];
        end
    end

    // size class: clamp to 32 bytes, bit length at least 8, less one
    always_comb begin
        sz_clamped = (size_in_reg < MIN_SIZE) ? MIN_SIZE : size_in_reg;
        bl         = bit_len(sz_clamped);
        if (bl < MIN_BITS) begin
            bl = MIN_BITS;
        end
        lg         = 5'(bl - 6'd1);
        lg_m1      = lg - 5'd1;
        align_mask = (32'd1 << lg) - 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == FSM_PREP) begin
            align_fail_reg <= (base_in_reg & align_mask) != 32'd0;
            attr_new_reg   <= 32'd1 | {26'd0, lg_m1, 1'b0} | flags_in_reg;
        end
    end

    // token injected at the head of the chain during prep
    always_comb begin
        head_tok            = '0;
        head_tok.vld        = (state_reg == FSM_PREP);
        head_tok.func       = func_reg;
        head_tok.base       = base_in_reg;
        head_tok.addr       = addr_in_reg;
    end

    assign tok[0] = head_tok;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        mpuacl_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1]),
            .wr       (wr)
        );
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == FSM_SCAN) && tok[TABLE_ENTRIES].vld) begin
            res_tok_reg <= tok[TABLE_ENTRIES];
        end
    end

    // decide: table write and result word
    always_comb begin
        logic [IDX_W+3:0] idx_ext;
        status_t          st;
        logic [OUT_IDX_W-1:0] oidx;
        logic [SLOT_W-1:0]    slot;
        logic [31:0]          bw;
        logic [31:0]          aw;

        wr           = '0;
        wr.base      = base_in_reg;
        wr.attr      = attr_new_reg;
        wr.prio      = prio_in_reg;
        dyn_cnt_next = dyn_cnt_reg;
        cnt_inc      = {1'b0, dyn_cnt_reg} + 4'd1;
        idx_ext      = '0;
        st           = ST_OK;
        slot         = '0;
        bw           = 32'd0;
        aw           = 32'd0;

        if (res_tok_reg.func == FUNC_SET) begin
            if (align_fail_reg) begin
                st = ST_BAD_ARG;
            end else if (res_tok_reg.hit) begin
                idx_ext = {4'd0, res_tok_reg.hit_idx};
                wr.idx  = res_tok_reg.hit_idx;
                wr.en   = load_out;
                if (size_in_reg == 32'd0) begin
                    wr.clear = 1'b1;
                end else begin
                    bw = base_in_reg;
                    aw = attr_new_reg;
                end
            end else if (res_tok_reg.free_found) begin
                idx_ext = {4'd0, res_tok_reg.free_idx};
                wr.idx  = res_tok_reg.free_idx;
                wr.en   = load_out;
                bw      = base_in_reg;
                aw      = attr_new_reg;
            end else begin
                st = ST_FULL;
            end
        end else begin
            if (res_tok_reg.hit) begin
                if (cnt_inc >= 4'(DYN_REGIONS)) begin
                    slot = '0;
                end else begin
                    slot = cnt_inc[SLOT_W-1:0];
                end
                if (load_out) begin
                    dyn_cnt_next = slot;
                end
                idx_ext = {4'd0, res_tok_reg.hit_idx};
                bw      = res_tok_reg.hit_base;
                aw      = res_tok_reg.hit_attr;
            end else begin
                st = ST_DENIED;
            end
        end
        oidx     = idx_ext[OUT_IDX_W-1:0];
        res_pack = {aw, bw, slot, oidx, st};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dyn_cnt_reg <= '0;
        end else begin
            dyn_cnt_reg <= dyn_cnt_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {7'd0, res_pack};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_dyn_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, dyn_cnt_reg} < 4'(DYN_REGIONS) || dyn_cnt_reg == '0)
        else $error("dynamic slot counter out of range");

    a_tail_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[TABLE_ENTRIES].vld |-> state_reg == FSM_SCAN)
        else $error("scan token left the chain outside the scan");

    a_accept_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> state_reg == FSM_PREP)
        else $error("accepted beat did not start prep");

    a_write_once: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> load_out && res_tok_reg.func == FUNC_SET)
        else $error("table write outside a set decision");

endmodule : mpu_acl_region_table

`default_nettype wire

// ===== rtl/core/mpuacl_cell.sv =====
// One table entry cell: holds an entry, checks the passing scan token and
// hands it on. Depends on mpuacl_pkg.
`default_nettype none

module mpuacl_cell (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [mpuacl_pkg::IDX_W-1:0] cell_idx,
    input  wire mpuacl_pkg::scan_tok_t        tok_in,
    output mpuacl_pkg::scan_tok_t             tok_out,
    input  wire mpuacl_pkg::cell_wr_t         wr
);
    import mpuacl_pkg::*;

    logic        valid_reg;
    logic [31:0] base_reg;
    logic [5:0]  size_log_reg;
    logic [31:0] attr_reg;
    logic [7:0]  prio_reg;

    scan_tok_t   tok_reg;
    scan_tok_t   tok_next;
    logic [31:0] mask;
    logic        match;

    // size log of 32 gives an empty mask: matches every address if the base is 0
    assign mask = size_log_reg[5] ? 32'd0 : (32'hFFFF_FFFF << size_log_reg[4:0]);

    always_comb begin
        tok_next = tok_in;
        if (tok_in.func == FUNC_FAULT) begin
            match = valid_reg && ((tok_in.addr & mask) == base_reg);
        end else begin
            match = valid_reg && (tok_in.base == base_reg);
        end
        if (!tok_in.hit && match) begin
            tok_next.hit      = 1'b1;
            tok_next.hit_idx  = cell_idx;
            tok_next.hit_base = base_reg;
            tok_next.hit_attr = attr_reg;
        end
        if (!tok_in.free_found && !valid_reg) begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr.en && (wr.idx == cell_idx)) begin
            valid_reg <= !wr.clear;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && (wr.idx == cell_idx)) begin
            if (wr.clear) begin
                base_reg     <= 32'd0;
                size_log_reg <= 6'd0;
                attr_reg     <= 32'd0;
                prio_reg     <= 8'd0;
            end else begin
                base_reg     <= wr.base;
                size_log_reg <= {1'b0, wr.attr[5:1]} + 6'd1;
                attr_reg     <= wr.attr;
                prio_reg     <= wr.prio;
            end
        end
    end

endmodule : mpuacl_cell

`default_nettype wire

// ===== verif/mpu_acl_region_table_tb.sv =====
// Self-checking bench for the region table: a directed table, then random set,
// erase and fault beats, checked against typed-in results or a behavioral copy
// of the table. Depends on mpuacl_pkg and mpu_acl_region_table.
`timescale 1ns / 1ps

module mpu_acl_region_table_tb;

    import mpuacl_pkg::*;

    localparam int RAND_ITEMS  = 1850;
    localparam int CALM_ITEMS  = 200;     // tail of the run with no idling
    localparam int PHASE_ITEMS = 150;     // fill / drain phase length
    localparam int DRAIN_WAIT  = 40;      // extra wait after the final drain
    localparam int CYCLE_LIMIT = 500_000;

    // Result beat, packed in m_tdata order (status in the low bits).
    typedef struct packed {
        logic [31:0] attr_word;
        logic [31:0] base_word;
        logic [2:0]  dyn_slot;
        logic [3:0]  entry_index;
        status_t     status;
    } region_result_t;

    typedef struct packed {
        func_t          func;
        logic [31:0]    base;
        logic [31:0]    size;
        logic [7:0]     prio;
        logic [31:0]    flags;
        logic [31:0]    addr;
        logic           typed;    // 1: use the typed-in result below
        region_result_t want;
    } dir_row_t;

    localparam region_result_t NO_WANT  = '0;
    localparam region_result_t R_DENIED = '{32'h0, 32'h0, 3'd0, 4'd0, ST_DENIED};
    localparam region_result_t R_BAD    = '{32'h0, 32'h0, 3'd0, 4'd0, ST_BAD_ARG};

    localparam int NDIR = 22;
    localparam dir_row_t DIR_ROWS [NDIR] = '{
        // lookups on an empty table miss
        '{FUNC_FAULT, 32'h0000_0000, 32'h0, 8'h00, 32'h0, 32'h0000_0000, 1'b1, R_DENIED},
        '{FUNC_FAULT, 32'h0000_0000, 32'h0, 8'h00, 32'h0, 32'hFFFF_FFFF, 1'b1, R_DENIED},
        // misaligned base for the 128-byte minimum
        '{FUNC_SET, 32'h0000_0001, 32'h0, 8'h00, 32'h0, 32'h0, 1'b1, R_BAD},
        // largest size, top half of the map
        '{FUNC_SET, 32'h8000_0000, 32'hFFFF_FFFF, 8'h00, 32'h0, 32'h0, 1'b1,
          '{32'h0000_003D, 32'h8000_0000, 3'd0, 4'd0, ST_OK}},
        // zero size with no match claims a 128-byte region at base 0
        '{FUNC_SET, 32'h0000_0000, 32'h0, 8'h01, 32'h0, 32'h0, 1'b1,
          '{32'h0000_000D, 32'h0000_0000, 3'd0, 4'd1, ST_OK}},
        // hits walk the dynamic slot 1, 2, then wrap to 0
        '{FUNC_FAULT, 32'h0, 32'h0, 8'h00, 32'h0, 32'h8000_1234, 1'b1,
          '{32'h0000_003D, 32'h8000_0000, 3'd1, 4'd0, ST_OK}},
        '{FUNC_FAULT, 32'h0, 32'h0, 8'h00, 32'h0, 32'h0000_007F, 1'b1,
          '{32'h0000_000D, 32'h0000_0000, 3'd2, 4'd1, ST_OK}},
        '{FUNC_FAULT, 32'h0, 32'h0, 8'h00, 32'h0, 32'h0000_0080, 1'b1, R_DENIED},
        '{FUNC_FAULT, 32'h0, 32'h0, 8'h00, 32'h0, 32'h0000_0000, 1'b1,
          '{32'h0000_000D, 32'h0000_0000, 3'd0, 4'd1, ST_OK}},
        // update of an existing base
        '{FUNC_SET, 32'h0000_0000, 32'h0000_1000, 8'h05, 32'h0000_0700, 32'h0, 1'b0, NO_WANT},
        // size below 32 is raised, base 0x40 is then misaligned
        '{FUNC_SET, 32'h0000_0040, 32'h0000_0005, 8'h00, 32'h0, 32'h0, 1'b1, R_BAD},
        // erase
        '{FUNC_SET, 32'h0000_0000, 32'h0, 8'h00, 32'h0, 32'h0, 1'b1,
          '{32'h0, 32'h0, 3'd0, 4'd1, ST_OK}},
        // flags over bits 5:1 push the size log to 32: base 0 matches all
        '{FUNC_SET, 32'h0000_0000, 32'h0000_0100, 8'hFF, 32'h0000_003E, 32'h0, 1'b0, NO_WANT},
        '{FUNC_FAULT, 32'h0, 32'h0, 8'h00, 32'h0, 32'h1234_5678, 1'b0, NO_WANT},
        // all-ones flags and priority on an update
        '{FUNC_SET, 32'h8000_0000, 32'h0000_0010, 8'hFF, 32'hFFFF_FFFF, 32'h0, 1'b1,
          '{32'hFFFF_FFFF, 32'h8000_0000, 3'd0, 4'd0, ST_OK}},
        '{FUNC_SET, 32'h0010_0000, 32'h8000_0000, 8'h00, 32'h0, 32'h0, 1'b1, R_BAD},
        '{FUNC_SET, 32'h0000_0000, 32'h0, 8'h00, 32'h0, 32'h0, 1'b1,
          '{32'h0, 32'h0, 3'd0, 4'd1, ST_OK}},
        '{FUNC_SET, 32'hFFFF_FF80, 32'h0, 8'h80, 32'h0, 32'h0, 1'b0, NO_WANT},
        '{FUNC_FAULT, 32'h0, 32'h0, 8'h00, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_WANT},
        // size log 32 with nonzero base never matches
        '{FUNC_FAULT, 32'h0, 32'h0, 8'h00, 32'h0, 32'h8000_0000, 1'b0, NO_WANT},
        '{FUNC_SET, 32'h1280_0000, 32'h00AB_CDEF, 8'h5A, 32'hA5A5_A5C0, 32'h0, 1'b0, NO_WANT},
        '{FUNC_FAULT, 32'h0, 32'h0, 8'h00, 32'h0, 32'h128A_BCDE, 1'b0, NO_WANT}
    };

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata  = '0;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;

    // Behavioral copy of the table
    logic        rt_valid [TABLE_ENTRIES];
    logic [31:0] rt_base  [TABLE_ENTRIES];
    logic [5:0]  rt_lg    [TABLE_ENTRIES];
    logic [31:0] rt_attr  [TABLE_ENTRIES];
    logic [7:0]  rt_prio  [TABLE_ENTRIES];
    logic [2:0]  dyn_ptr;

    region_result_t pending_results [$];
    int  errors    = 0;
    int  cycle_cnt = 0;
    bit  calm      = 1'b0;

    mpu_acl_region_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // log2 region size for a requested byte count (7..31)
    function automatic logic [4:0] region_order(input logic [31:0] size);
        logic [31:0] sz;
        int          nbits;
        sz    = (size < MIN_SIZE) ? MIN_SIZE : size;
        nbits = 0;
        for (int b = 0; b < 32; b++) begin
            if (sz[b]) nbits = b + 1;
        end
        if (nbits < int'(MIN_BITS)) nbits = int'(MIN_BITS);
        return 5'(nbits - 1);
    endfunction

    // keeps address bits at and above lg; lg of 32 gives zero
    function automatic logic [31:0] span_mask(input logic [5:0] lg);
        return 32'(~((64'd1 << lg) - 64'd1));
    endfunction

    function automatic int pick_valid_entry();
        int live [$];
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (rt_valid[i]) live.push_back(i);
        end
        if (live.size() == 0) return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Applies one beat to the table copy and returns its result.
    function automatic region_result_t resolve_region_beat(
        input func_t       func,
        input logic [31:0] base,
        input logic [31:0] size,
        input logic [7:0]  prio,
        input logic [31:0] flags,
        input logic [31:0] addr
    );
        region_result_t r;
        logic [4:0]     ord;
        logic [31:0]    attr;
        int             slot;
        int             nxt;
        r    = '0;
        slot = -1;
        if (func == FUNC_SET) begin
            ord = region_order(size);
            if ((base & ~span_mask({1'b0, ord})) != 32'd0) begin
                r.status = ST_BAD_ARG;
                return r;
            end
            attr = 32'd1 | (32'(ord - 5'd1) << 1) | flags;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot < 0 && rt_valid[i] && rt_base[i] == base) slot = i;
            end
            if (slot >= 0 && size == 32'd0) begin
                rt_valid[slot] = 1'b0;
                rt_base[slot]  = '0;
                rt_lg[slot]    = '0;
                rt_attr[slot]  = '0;
                rt_prio[slot]  = '0;
                r.status       = ST_OK;
                r.entry_index  = 4'(slot);
                return r;
            end
            if (slot < 0) begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (slot < 0 && !rt_valid[i]) slot = i;
                end
                if (slot < 0) begin
                    r.status = ST_FULL;
                    return r;
                end
                rt_valid[slot] = 1'b1;
                rt_base[slot]  = base;
            end
            rt_prio[slot] = prio;
            rt_attr[slot] = attr;
            rt_lg[slot]   = 6'(attr[5:1]) + 6'd1;
            r.status      = ST_OK;
            r.entry_index = 4'(slot);
            r.base_word   = base;
            r.attr_word   = attr;
        end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot < 0 && rt_valid[i] && (addr & span_mask(rt_lg[i])) == rt_base[i])
                    slot = i;
            end
            if (slot < 0) begin
                r.status = ST_DENIED;
                return r;
            end
            nxt = int'(dyn_ptr) + 1;
            if (nxt >= DYN_REGIONS) nxt = 0;
            dyn_ptr       = 3'(nxt);
            r.status      = ST_OK;
            r.entry_index = 4'(slot);
            r.dyn_slot    = dyn_ptr;
            r.base_word   = rt_base[slot];
            r.attr_word   = rt_attr[slot];
        end
        return r;
    endfunction

    // Drives one beat, waits for acceptance, queues the expected result.
    task automatic send_request(
        input func_t          func,
        input logic [31:0]    base,
        input logic [31:0]    size,
        input logic [7:0]     prio,
        input logic [31:0]    flags,
        input logic [31:0]    addr,
        input logic           typed,
        input region_result_t want
    );
        region_result_t pred;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {addr, flags, prio, size, base};
        do @(posedge aclk); while (!s_tready);
        pred = resolve_region_beat(func, base, size, prio, flags, addr);
        pending_results.push_back(typed ? want : pred);
    endtask

    // Sender holds off until every queued result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Result checker
    always @(posedge aclk) begin
        region_result_t got;
        region_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = region_result_t'(m_tdata[72:0]);
            if (pending_results.size() == 0) begin
                if (errors < 10) $display("unexpected result beat: %h", m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[79:73] !== 7'd0) begin
                    if (errors < 10) begin
                        $display("mismatch: exp st=%0d idx=%0d slot=%0d base=%h attr=%h",
                                 want.status, want.entry_index, want.dyn_slot,
                                 want.base_word, want.attr_word);
                        $display("          got st=%0d idx=%0d slot=%0d base=%h attr=%h pad=%h",
                                 got.status, got.entry_index, got.dyn_slot,
                                 got.base_word, got.attr_word, m_tdata[79:73]);
                    end
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: short stall bursts, occasional long ready stretches
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 19) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        func_t       func;
        logic [31:0] rb, rs, rf, ra;
        logic [7:0]  rp;
        logic [4:0]  ord;
        int          pick, vi, k, erase_pct;

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            rt_valid[i] = 1'b0;
            rt_base[i]  = '0;
            rt_lg[i]    = '0;
            rt_attr[i]  = '0;
            rt_prio[i]  = '0;
        end
        dyn_ptr   = '0;
        erase_pct = 4;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[r])
            send_request(DIR_ROWS[r].func, DIR_ROWS[r].base, DIR_ROWS[r].size,
                         DIR_ROWS[r].prio, DIR_ROWS[r].flags, DIR_ROWS[r].addr,
                         DIR_ROWS[r].typed, DIR_ROWS[r].want);
        wait_drained();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // alternate phases that fill the table to full and drain it
            if (n % PHASE_ITEMS == 0) erase_pct = ((n / PHASE_ITEMS) % 2 == 1) ? 40 : 4;
            if (n == RAND_ITEMS / 2) wait_drained();
            calm = (n >= RAND_ITEMS - CALM_ITEMS);

            // unused fields carry noise
            func = ($urandom_range(0, 99) < 50) ? FUNC_SET : FUNC_FAULT;
            rb   = $urandom;
            rs   = $urandom;
            rp   = 8'($urandom);
            rf   = $urandom;
            ra   = $urandom;
            vi   = pick_valid_entry();

            if (func == FUNC_SET) begin
                pick = $urandom_range(0, 99);
                k    = $urandom_range(0, 9);
                if (k == 0) rs = 32'd0;
                else if (k < 3) rs = 32'($urandom_range(0, 255));
                else if (k > 3) begin
                    // mostly small regions
                    ord = 5'($urandom_range(0, 19));
                    rs  = (32'd1 << ord) | ($urandom & ((32'd1 << ord) - 32'd1));
                end
                if (vi >= 0 && pick < erase_pct) begin
                    rb = rt_base[vi];
                    rs = 32'd0;
                end else if (vi >= 0 && pick < erase_pct + 30) begin
                    rb = rt_base[vi];
                end else if (pick < 93) begin
                    rb = $urandom & span_mask({1'b0, region_order(rs)});
                end
                // else: raw base, nearly always misaligned
                if ($urandom_range(0, 4) != 0) rf = rf & ~32'h0000_003E;
            end else if (vi >= 0 && $urandom_range(0, 99) < 65) begin
                ra = rt_base[vi] | ($urandom & ~span_mask(rt_lg[vi]));
            end

            send_request(func, rb, rs, rp, rf, ra, 1'b0, NO_WANT);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        errors += pending_results.size();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
